// ===== hw/rtl/utf8_to_ucs2_decoder_assert.svh =====
// Assertion macros for the UTF-8 to UCS-2 decoder.
// Expects clk_i and rst_ni in the scope of the module that expands them.
`ifndef UTF8_TO_UCS2_DECODER_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_ASSERT_SVH

// Checked only while out of reset.
`define UTD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("decoder assertion failed");

// Checked at every edge, reset included.
`define UTD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("decoder invariant violated");

`endif

// ===== hw/rtl/utd_pkg.sv =====
// Shared types and constants of the UTF-8 to UCS-2 decoder.
// No dependencies.
package utd_pkg;

  // Byte class masks and tags
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Result queue geometry
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;

  typedef struct packed {
    logic [15:0] code_point;
    logic        is_end;
    logic [15:0] char_count;
  } utd_result_t;

endpackage

// ===== hw/rtl/utd_byte_if.sv =====
// Byte request channel of the decoder: valid/ready plus one UTF-8 byte.
// Depends on nothing but the handshake convention.
interface utd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// ===== hw/rtl/utd_unit_if.sv =====
// Result request channel of the decoder: valid/ready plus one code unit or end result.
// Depends on nothing but the handshake convention.
interface utd_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_point;
  logic        is_end;
  logic [15:0] char_count;

  modport source (output valid, output code_point, output is_end, output char_count,
                  input ready);
  modport sink   (input valid, input code_point, input is_end, input char_count,
                  output ready);
endinterface

// ===== hw/rtl/utf8_to_ucs2_decoder.sv =====
// Channel   | Dir | Payload                              | Handshake
// in_i      | in  | data_byte[7:0], end_of_buffer        | valid/ready
// out_o     | out | code_point[15:0], is_end, char_count | valid/ready
//
// One byte is decoded in the cycle it is accepted; results enter a 4-entry queue.
// Sustained rate is one byte per cycle, bounded by one result popped per cycle.
// A last byte that also completes a character pushes two results in one cycle.
// in_i.ready is high while the queue holds at most two results.
// rst_ni clears the decode state and empties the queue; no clearing pass.
`include "utf8_to_ucs2_decoder_assert.svh"

module utf8_to_ucs2_decoder
  import utd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  utd_byte_if.sink  in_i,
  utd_unit_if.source out_o
);

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_ONE  = 2'd1,
    PEND_TWO  = 2'd2
  } pend_e;

  pend_e          pend_q, pend_d;
  logic [15:0]    partial_q, partial_d;
  logic           halted_q, halted_d;
  logic [15:0]    count_q, count_inc;

  utd_result_t            res_mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [RES_PTR_W:0]     fill_q;

  logic        in_fire, out_fire;
  logic        emit;
  logic [15:0] char_cp;
  logic [7:0]  byte_in;
  logic        last;
  utd_result_t char_res, end_res, first_res;
  logic        push_first, push_second;
  logic [1:0]  push_n;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign byte_in  = in_i.data_byte;
  assign last     = in_i.end_of_buffer;

  assign in_i.ready = (fill_q <= (RES_PTR_W+1)'(RES_DEPTH - 2));

  // Decode one byte against the pending sequence
  always_comb begin
    pend_d    = pend_q;
    partial_d = partial_q;
    halted_d  = halted_q;
    emit      = 1'b0;
    char_cp   = '0;
    if (!halted_q) begin
      unique case (pend_q)
        PEND_NONE: begin
          if (!byte_in[7]) begin
            emit    = 1'b1;
            char_cp = {9'b0, byte_in[6:0]};
          end else if ((byte_in & LEAD2_MASK) == LEAD2_TAG) begin
            partial_d = {5'b0, byte_in[4:0], 6'b0};
            pend_d    = PEND_ONE;
          end else if ((byte_in & LEAD3_MASK) == LEAD3_TAG) begin
            partial_d = {byte_in[3:0], 12'b0};
            pend_d    = PEND_TWO;
          end else begin
            halted_d = 1'b1;
          end
        end
        default: begin
          if ((byte_in & CONT_MASK) != CONT_TAG) begin
            // drop the partial sequence
            halted_d  = 1'b1;
            pend_d    = PEND_NONE;
            partial_d = '0;
          end else if (pend_q == PEND_TWO) begin
            partial_d = partial_q | {4'b0, byte_in[5:0], 6'b0};
            pend_d    = PEND_ONE;
          end else begin
            emit      = 1'b1;
            char_cp   = partial_q | {10'b0, byte_in[5:0]};
            pend_d    = PEND_NONE;
            partial_d = '0;
          end
        end
      endcase
    end
  end

  assign count_inc = (emit && (count_q != COUNT_MAX)) ? count_q + 16'd1 : count_q;

  assign char_res  = '{code_point: char_cp, is_end: 1'b0, char_count: 16'd0};
  assign end_res   = '{code_point: 16'd0, is_end: 1'b1, char_count: count_inc};
  assign first_res = emit ? char_res : end_res;

  assign push_first  = in_fire && (emit || last);
  assign push_second = in_fire && emit && last;
  assign push_n      = {1'b0, push_first} + {1'b0, push_second};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= PEND_NONE;
      partial_q <= '0;
      halted_q  <= 1'b0;
      count_q   <= '0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      fill_q    <= '0;
    end else begin
      if (in_fire) begin
        if (last) begin
          // end of buffer: start the next one clean
          pend_q    <= PEND_NONE;
          partial_q <= '0;
          halted_q  <= 1'b0;
          count_q   <= '0;
        end else begin
          pend_q    <= pend_d;
          partial_q <= partial_d;
          halted_q  <= halted_d;
          count_q   <= count_inc;
        end
      end
      wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push_n);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
      end
      fill_q <= fill_q + (RES_PTR_W+1)'(push_n) - (RES_PTR_W+1)'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_first) begin
      res_mem_q[wr_ptr_q] <= first_res;
    end
    if (push_second) begin
      res_mem_q[wr_ptr_q + RES_PTR_W'(1)] <= end_res;
    end
  end

  assign out_o.valid      = (fill_q != '0);
  assign out_o.code_point = res_mem_q[rd_ptr_q].code_point;
  assign out_o.is_end     = res_mem_q[rd_ptr_q].is_end;
  assign out_o.char_count = res_mem_q[rd_ptr_q].char_count;

  `UTD_ASSERT_ALWAYS(a_fill_bound, !rst_ni || fill_q <= (RES_PTR_W+1)'(RES_DEPTH))
  `UTD_ASSERT(a_end_clears,
      (in_fire && last) |=> (pend_q == PEND_NONE && !halted_q && count_q == '0))
  `UTD_ASSERT(a_halt_no_partial, halted_q |-> (pend_q == PEND_NONE && partial_q == '0))
  `UTD_ASSERT(a_halted_silent,
      (in_fire && halted_q && !last) |=> (fill_q <= $past(fill_q)))

endmodule

// ===== bench/tb_utf8_to_ucs2_decoder.sv =====
`timescale 1ns / 100ps
// Testbench for utf8_to_ucs2_decoder: drives UTF-8 buffers into the byte channel and checks
// every code unit and end result against a built-in decoder model. Depends on utd_pkg and the
// utd_byte_if / utd_unit_if channel interfaces.
module tb_utf8_to_ucs2_decoder;
  import utd_pkg::*;

  localparam logic [7:0] LEAD4_TAG = 8'hF0;  // first lead the block does not support
  localparam int RANDOM_BYTES = 1350;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  utd_byte_if byte_if();
  utd_unit_if unit_if();

  utf8_to_ucs2_decoder u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_if),
    .out_o (unit_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Decoder model state
  logic [1:0]  dec_pending = '0;
  logic [15:0] dec_partial = '0;
  logic        dec_halted  = 1'b0;
  logic [15:0] dec_count   = '0;
  int          sent_bytes  = 0;

  utd_result_t unit_exp_q[$];
  logic [7:0]  utf8_bytes[$];
  int          mismatch_count = 0;

  // Idle controls
  bit tx_burst  = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold   = 0;
  int rx_stall  = 0;
  int rx_phase  = 0;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_unit(input logic [15:0] cp);
    utd_result_t res;
    if (dec_count != COUNT_MAX) dec_count++;
    res.code_point = cp;
    res.is_end     = 1'b0;
    res.char_count = '0;
    unit_exp_q.push_back(res);
  endtask

  // Advance the decoder model by one accepted byte.
  task automatic predict_units(input logic [7:0] b, input logic is_last);
    utd_result_t res;
    if (!dec_halted) begin
      if (dec_pending == 2'd0) begin
        if (b[7] == 1'b0) begin
          push_unit({8'h00, b});
        end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
          dec_partial = {5'b0, b[4:0], 6'b0};
          dec_pending = 2'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
          dec_partial = {b[3:0], 12'b0};
          dec_pending = 2'd2;
        end else begin
          dec_halted = 1'b1;
        end
      end else if ((b & CONT_MASK) != CONT_TAG) begin
        // drop the open sequence; the bad byte is not a new lead
        dec_halted  = 1'b1;
        dec_pending = 2'd0;
        dec_partial = '0;
      end else if (dec_pending == 2'd2) begin
        dec_partial = dec_partial | {4'b0, b[5:0], 6'b0};
        dec_pending = 2'd1;
      end else begin
        push_unit(dec_partial | {10'b0, b[5:0]});
        dec_pending = 2'd0;
        dec_partial = '0;
      end
    end
    if (is_last) begin
      res.code_point = '0;
      res.is_end     = 1'b1;
      res.char_count = dec_count;
      unit_exp_q.push_back(res);
      dec_pending = 2'd0;
      dec_partial = '0;
      dec_halted  = 1'b0;
      dec_count   = '0;
    end
  endtask

  // Offer one byte and hold it until the request is taken. Called at a rising edge.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    bit took;
    gap = tx_burst ? 0 : idle_len();
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid         <= 1'b1;
    byte_if.data_byte     <= b;
    byte_if.end_of_buffer <= is_last;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = byte_if.ready;
      @(posedge clk_i);
    end
    sent_bytes++;
    predict_units(b, is_last);
  endtask

  task automatic send_buffer();
    foreach (utf8_bytes[i]) send_byte(utf8_bytes[i], i == utf8_bytes.size() - 1);
  endtask

  task automatic wait_results_drained();
    byte_if.valid <= 1'b0;
    while (unit_exp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic push_random_char();
    logic [31:0] r;
    r = $urandom();
    case (r[31:30])
      2'd0, 2'd1: utf8_bytes.push_back({1'b0, r[6:0]});
      2'd2: begin
        utf8_bytes.push_back(LEAD2_TAG | {3'b0, r[4:0]});
        utf8_bytes.push_back(CONT_TAG | {2'b0, r[10:5]});
      end
      default: begin
        utf8_bytes.push_back(LEAD3_TAG | {4'b0, r[3:0]});
        utf8_bytes.push_back(CONT_TAG | {2'b0, r[9:4]});
        utf8_bytes.push_back(CONT_TAG | {2'b0, r[15:10]});
      end
    endcase
  endtask

  // Mostly well-formed buffers; the rest carry a bad byte, a bad lead, a cut sequence or noise.
  task automatic build_random_buffer();
    int shape;
    int nchars;
    logic [31:0] r;
    utf8_bytes.delete();
    shape  = $urandom_range(0, 9);
    nchars = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
    r = $urandom();
    if (shape == 9) begin
      repeat ($urandom_range(1, 8)) begin
        r = $urandom();
        utf8_bytes.push_back(r[7:0]);
      end
    end else begin
      repeat (nchars) push_random_char();
      if (shape == 6) begin
        utf8_bytes.push_back(r[0] ? (CONT_TAG | {2'b0, r[6:1]}) : (LEAD4_TAG | {4'b0, r[4:1]}));
        repeat ($urandom_range(0, 4)) push_random_char();
      end else if (shape == 7) begin
        utf8_bytes[$urandom_range(0, utf8_bytes.size() - 1)] = r[7:0];
      end else if (shape == 8) begin
        // leave a sequence open at the end of the buffer
        if (r[8]) begin
          utf8_bytes.push_back(LEAD2_TAG | {3'b0, r[4:0]});
        end else begin
          utf8_bytes.push_back(LEAD3_TAG | {4'b0, r[3:0]});
          if (r[9]) utf8_bytes.push_back(CONT_TAG | {2'b0, r[15:10]});
        end
      end
    end
  endtask

  task automatic test_directed();
    utf8_bytes = '{8'h00, 8'h7F, 8'hC0, 8'h80, 8'hDF, 8'hBF};
    send_buffer();
    // last byte completes a character: code unit and end result together
    utf8_bytes = '{8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF};
    send_buffer();
    // unsupported leads, then ignored bytes
    utf8_bytes = '{8'hBF, 8'h41};
    send_buffer();
    utf8_bytes = '{8'h41, 8'hF0};
    send_buffer();
    utf8_bytes = '{8'hFF};
    send_buffer();
    // bad continuation in a two- and a three-byte sequence
    utf8_bytes = '{8'hC3, 8'h41, 8'h42};
    send_buffer();
    utf8_bytes = '{8'hE2, 8'h82, 8'h28};
    send_buffer();
    // truncated sequence at the end of the buffer
    utf8_bytes = '{8'h41, 8'hE2, 8'h82};
    send_buffer();
    wait_results_drained();
  endtask

  task automatic test_result_backpressure();
    tx_burst = 1'b1;
    rx_hold  = 300;
    utf8_bytes.delete();
    repeat (40) push_random_char();
    send_buffer();
    tx_burst = 1'b0;
    wait_results_drained();
  endtask

  task automatic test_random_buffers();
    while (sent_bytes < RANDOM_BYTES) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      build_random_buffer();
      send_buffer();
      if ($urandom_range(0, 29) == 0) wait_results_drained();
    end
    tx_burst = 1'b0;
  endtask

  // Result receiver: random stalls, quiet stretches, and the long hold-off on request.
  initial begin
    unit_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rx_phase++;
      if (rx_phase == 256) begin
        rx_phase  = 0;
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      if (rx_hold > 0) begin
        unit_if.ready <= 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        unit_if.ready <= 1'b0;
        rx_stall--;
      end else begin
        unit_if.ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) rx_stall = idle_len();
      end
    end
  end

  // Compare each result at the falling edge before the rising edge that takes it.
  always @(negedge clk_i) begin
    utd_result_t exp_res;
    if (rst_ni && unit_if.valid && unit_if.ready) begin
      if (unit_exp_q.size() == 0) begin
        $error("unexpected result: code_point %h is_end %b char_count %0d",
               unit_if.code_point, unit_if.is_end, unit_if.char_count);
        mismatch_count++;
      end else begin
        exp_res = unit_exp_q.pop_front();
        if (unit_if.code_point !== exp_res.code_point) begin
          $error("code_point: expected %h, got %h", exp_res.code_point, unit_if.code_point);
          mismatch_count++;
        end
        if (unit_if.is_end !== exp_res.is_end) begin
          $error("is_end: expected %b, got %b", exp_res.is_end, unit_if.is_end);
          mismatch_count++;
        end
        if (unit_if.char_count !== exp_res.char_count) begin
          $error("char_count: expected %0d, got %0d", exp_res.char_count, unit_if.char_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #6000000;
    $display("FAIL utf8_to_ucs2_decoder");
    $finish;
  end

  initial begin
    byte_if.valid         = 1'b0;
    byte_if.data_byte     = '0;
    byte_if.end_of_buffer = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_result_backpressure();
    test_random_buffers();

    wait_results_drained();
    repeat (16) @(posedge clk_i);
    if (unit_exp_q.size() != 0) begin
      $error("%0d results never arrived", unit_exp_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS utf8_to_ucs2_decoder");
    end else begin
      $display("FAIL utf8_to_ucs2_decoder");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/utd_pkg.sv
hw/rtl/utd_byte_if.sv
hw/rtl/utd_unit_if.sv
hw/rtl/utf8_to_ucs2_decoder.sv
bench/tb_utf8_to_ucs2_decoder.sv
